>>> hdl/adrt_pkg.sv
`timescale 1ns / 1ps
package adrt_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] RESET_MIN_RTT = 16'd100;
  localparam logic [15:0] RESET_BIG_RTT = 16'd200;

  // config register index (paddr[2])
  localparam logic REG_MIN_RTT = 1'b0;
  localparam logic REG_BIG_RTT = 1'b1;

  localparam logic FUNC_SEND = 1'b0;
  localparam logic FUNC_ACK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_FWD  = 2'd0,
    KIND_RETX = 2'd1,
    KIND_DUP  = 2'd2,
    KIND_FULL = 2'd3
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // item accepted
    logic rd_en;       // table read issued
    logic pick;        // scan looks for the smallest expired key
    logic clr_scan;    // start of a pick pass
    logic decide;      // send verdict
    logic emit;        // emit the picked entry
    logic final_slot;  // emit fills the last result slot
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ack;
    logic any_exp;
  } sts_t;

endpackage

>>> hdl/ack_driven_retransmit_table_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Fields
// command   in         start & !busy                 func, name_tag, media_time, fragment,
//                                                    reliable, packet_handle
// result    out        result_valid_o, 1 cycle       result_kind, out_tag, out_time,
//                                                    out_fragment, out_handle, last
// config    in         APB psel&penable&pwrite       min_rtt @0x0, big_rtt @0x4
//
// Per item: an unreliable send goes straight to its verdict; a reliable send makes one pass
// over the table memory, one entry read per cycle, for the duplicate check.
// Ack: one pass for the match/expiry check, plus one more pass per resent item,
// each a full pass of the single read port picking the smallest key.
// Each result is registered and shows in the cycle after its decide/emit cycle; a new
// item can be taken in the first cycle busy is low.
// Reset clears valid bits, highest acked time and control; the table payload
// memory is not cleared. Results cannot be stalled by the receiver.
module ack_driven_retransmit_table_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [31:0] name_tag_i,
  input  logic [31:0] media_time_i,
  input  logic [7:0]  fragment_i,
  input  logic        reliable_i,
  input  logic [15:0] packet_handle_i,
  // results
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [31:0] out_tag_o,
  output logic [31:0] out_time_o,
  output logic [7:0]  out_fragment_o,
  output logic [15:0] out_handle_o,
  output logic        last_o
);
  import adrt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [15:0]   min_rtt_q, big_rtt_q;
  logic          cfg_wr;
  logic          accept;
  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] rd_addr;

  // config registers; register index is paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {16'd0, (paddr[2] == REG_BIG_RTT) ? big_rtt_q : min_rtt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rtt_q <= RESET_MIN_RTT;
      big_rtt_q <= RESET_BIG_RTT;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MIN_RTT: min_rtt_q <= pwdata[15:0];
        REG_BIG_RTT: big_rtt_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;

  adrt_ctrl #(.DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .func_i    (func_i),
    .reliable_i(reliable_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .busy_o    (busy)
  );

  adrt_dpath #(.DEPTH(TABLE_DEPTH)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .func_i         (func_i),
    .name_tag_i     (name_tag_i),
    .media_time_i   (media_time_i),
    .fragment_i     (fragment_i),
    .reliable_i     (reliable_i),
    .packet_handle_i(packet_handle_i),
    .min_rtt_i      (min_rtt_q),
    .big_rtt_i      (big_rtt_q),
    .sts_o          (sts),
    .res_vld_o      (result_valid_o),
    .result_kind_o  (result_kind_o),
    .out_tag_o      (out_tag_o),
    .out_time_o     (out_time_o),
    .out_fragment_o (out_fragment_o),
    .out_handle_o   (out_handle_o),
    .last_o         (last_o)
  );

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept == cmd.load)
    else $error("load strobe disagrees with accept");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after accept");
  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without work");
endmodule

>>> hdl/adrt_ram.sv
`timescale 1ns / 1ps
module adrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/adrt_ctrl.sv
`timescale 1ns / 1ps
module adrt_ctrl #(
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     func_i,
  input  logic                     reliable_i,
  input  adrt_pkg::sts_t           sts_i,
  output adrt_pkg::cmd_t           cmd_o,
  output logic [$clog2(DEPTH)-1:0] rd_addr_o,
  output logic                     busy_o
);
  import adrt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_PICK, S_PSCAN, S_EMIT
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [NW-1:0]  n_q, n_d;
  logic           scan_end;

  assign scan_end  = (cnt_q == CW'(DEPTH));
  assign rd_addr_o = cnt_q[AW-1:0];
  assign busy_o    = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          n_d        = '0;
          state_d    = (func_i == FUNC_SEND && !reliable_i) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN, S_PSCAN: begin
        cmd_o.pick = (state_q == S_PSCAN);
        if (scan_end) begin
          if (state_q == S_PSCAN) state_d = S_EMIT;
          else state_d = sts_i.ack ? S_PICK : S_DECIDE;
        end else begin
          cmd_o.rd_en = 1'b1;
          cnt_d       = cnt_q + CW'(1);
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_IDLE;
      end
      S_PICK: begin
        if (!sts_i.any_exp || n_q == NW'(MAX_RESULTS)) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.clr_scan = 1'b1;
          cnt_d          = '0;
          state_d        = S_PSCAN;
        end
      end
      S_EMIT: begin
        cmd_o.emit       = 1'b1;
        cmd_o.final_slot = (n_q == NW'(MAX_RESULTS - 1));
        n_d              = n_q + NW'(1);
        state_d          = S_PICK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
    end
  end

  a_emit_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (n_q < NW'(MAX_RESULTS)))
    else $error("emit beyond result limit");
  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("scan counter overran");
  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == S_IDLE))
    else $error("load outside idle");
endmodule

>>> hdl/adrt_dpath.sv
`timescale 1ns / 1ps
module adrt_dpath #(
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  adrt_pkg::cmd_t           cmd_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     func_i,
  input  logic [31:0]              name_tag_i,
  input  logic [31:0]              media_time_i,
  input  logic [7:0]               fragment_i,
  input  logic                     reliable_i,
  input  logic [15:0]              packet_handle_i,
  input  logic [15:0]              min_rtt_i,
  input  logic [15:0]              big_rtt_i,
  output adrt_pkg::sts_t           sts_o,
  output logic                     res_vld_o,
  output logic [1:0]               result_kind_o,
  output logic [31:0]              out_tag_o,
  output logic [31:0]              out_time_o,
  output logic [7:0]               out_fragment_o,
  output logic [15:0]              out_handle_o,
  output logic                     last_o
);
  import adrt_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int REC_W = 32 + 32 + 8 + 16;

  // latched item
  logic        func_q, rel_q;
  logic [31:0] tag_q, time_q;
  logic [7:0]  frag_q;
  logic [15:0] hdl_q;

  logic [31:0] hat_q, hat_d, thr_q, thr_d;
  logic [15:0] gap;
  logic [DEPTH-1:0] valid_q, valid_d, exp_q, exp_d, rest;
  logic        dup_q, dup_d, found_q, found_d;
  logic        rd_vld_q;
  logic [AW-1:0] rd_idx_q, best_idx_q, free_idx;
  logic        full;

  logic [31:0] best_tag_q, best_time_q;
  logic [7:0]  best_frag_q;
  logic [15:0] best_hdl_q;

  logic [REC_W-1:0] rdata;
  logic [31:0] r_tag, r_time;
  logic [7:0]  r_frag;
  logic [15:0] r_hdl;
  logic        hit, less, take, wr_en;

  adrt_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(free_idx),
    .wdata_i({tag_q, time_q, frag_q, hdl_q}),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  assign {r_tag, r_time, r_frag, r_hdl} = rdata;

  // expiry threshold, saturating
  assign gap   = (big_rtt_i >= min_rtt_i) ? (big_rtt_i - min_rtt_i) : 16'd0;
  assign thr_d = (hat_q >= {16'd0, gap}) ? (hat_q - {16'd0, gap}) : 32'd0;
  assign hat_d = (func_i == FUNC_ACK && media_time_i > hat_q) ? media_time_i : hat_q;

  assign hit  = valid_q[rd_idx_q] && ({r_tag, r_time, r_frag} == {tag_q, time_q, frag_q});
  assign less = {r_tag, r_time, r_frag} < {best_tag_q, best_time_q, best_frag_q};
  assign take = rd_vld_q && cmd_i.pick && exp_q[rd_idx_q] && (!found_q || less);

  // lowest free entry
  always_comb begin
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = AW'(i);
    end
  end
  assign full  = &valid_q;
  assign wr_en = cmd_i.decide && rel_q && !dup_q && !full;
  assign rest  = exp_q & ~(DEPTH'(1) << best_idx_q);

  assign sts_o.ack     = func_q;
  assign sts_o.any_exp = |exp_q;

  always_comb begin
    valid_d = valid_q;
    exp_d   = exp_q;
    dup_d   = dup_q;
    found_d = found_q;
    if (cmd_i.load) begin
      exp_d = '0;
      dup_d = 1'b0;
    end
    if (cmd_i.clr_scan) found_d = 1'b0;
    if (rd_vld_q && !cmd_i.pick) begin
      if (hit) dup_d = 1'b1;
      if (func_q == FUNC_ACK) begin
        if (hit) valid_d[rd_idx_q] = 1'b0;
        exp_d[rd_idx_q] = valid_q[rd_idx_q] && !hit && (r_time < thr_q);
      end
    end
    if (take) found_d = 1'b1;
    if (wr_en) valid_d[free_idx] = 1'b1;
    if (cmd_i.emit) begin
      valid_d[best_idx_q] = 1'b0;
      exp_d[best_idx_q]   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      exp_q     <= '0;
      hat_q     <= '0;
      dup_q     <= 1'b0;
      found_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      res_vld_o <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      exp_q     <= exp_d;
      dup_q     <= dup_d;
      found_q   <= found_d;
      rd_vld_q  <= cmd_i.rd_en;
      res_vld_o <= cmd_i.decide || cmd_i.emit;
      if (cmd_i.load) hat_q <= hat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q    <= thr_d;
    rd_idx_q <= rd_addr_i;
    if (cmd_i.load) begin
      func_q <= func_i;
      rel_q  <= reliable_i;
      tag_q  <= name_tag_i;
      time_q <= media_time_i;
      frag_q <= fragment_i;
      hdl_q  <= packet_handle_i;
    end
    if (take) begin
      best_idx_q  <= rd_idx_q;
      best_tag_q  <= r_tag;
      best_time_q <= r_time;
      best_frag_q <= r_frag;
      best_hdl_q  <= r_hdl;
    end
    if (cmd_i.decide) begin
      if (!rel_q) result_kind_o <= KIND_FWD;
      else if (dup_q) result_kind_o <= KIND_DUP;
      else if (full) result_kind_o <= KIND_FULL;
      else result_kind_o <= KIND_FWD;
      out_tag_o      <= tag_q;
      out_time_o     <= time_q;
      out_fragment_o <= frag_q;
      out_handle_o   <= hdl_q;
      last_o         <= 1'b1;
    end else if (cmd_i.emit) begin
      result_kind_o  <= KIND_RETX;
      out_tag_o      <= best_tag_q;
      out_time_o     <= best_time_q;
      out_fragment_o <= best_frag_q;
      out_handle_o   <= best_hdl_q;
      last_o         <= cmd_i.final_slot || !(|rest);
    end
  end

  a_exp_in_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q & ~valid_q) == '0)
    else $error("expired entry not valid");
  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> found_q)
    else $error("emit without a picked entry");
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !valid_q[free_idx])
    else $error("insert over a live entry");
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && (result_kind_o == KIND_DUP || result_kind_o == KIND_FULL)) |-> last_o)
    else $error("reject not marked last");
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import adrt_pkg::*;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        func;
    logic [31:0] tag;
    logic [31:0] mtime;
    logic [7:0]  frag;
    logic        rel;
    logic [15:0] handle;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag;
    logic [31:0] mtime;
    logic [7:0]  frag;
    logic [15:0] handle;
    logic        last;
  } res_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic func_i = 1'b0, reliable_i = 1'b0;
  logic [31:0] name_tag_i = '0, media_time_i = '0;
  logic [7:0] fragment_i = '0;
  logic [15:0] packet_handle_i = '0;
  logic result_valid_o;
  logic [1:0] result_kind_o;
  logic [31:0] out_tag_o, out_time_o;
  logic [7:0] out_fragment_o;
  logic [15:0] out_handle_o;
  logic last_o;

  ack_driven_retransmit_table_core #(.TABLE_DEPTH(DEPTH)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the retransmit table
  logic        tbl_valid [DEPTH];
  cmd_item_t   tbl_entry [DEPTH];
  logic [31:0] acked_max;
  logic [15:0] rtt_min, rtt_big;

  cmd_item_t pending_cmds[$];
  res_item_t expected_results[$];
  int  fail_count = 0;
  int  cycles = 0;
  logic quiet_stretch = 1'b0;
  logic driving = 1'b0;

  function automatic logic key_below(cmd_item_t a, cmd_item_t b);
    if (a.tag != b.tag) return a.tag < b.tag;
    if (a.mtime != b.mtime) return a.mtime < b.mtime;
    return a.frag < b.frag;
  endfunction

  // compute results of one accepted command and update the shadow table
  task automatic predict_table(input cmd_item_t c);
    int hit, slot, best, n;
    logic [31:0] gap, thr;
    logic aged [DEPTH];
    res_item_t r;
    hit = -1; slot = -1; n = 0;
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i] && tbl_entry[i].tag == c.tag && tbl_entry[i].mtime == c.mtime &&
          tbl_entry[i].frag == c.frag && hit < 0) hit = i;
    if (c.func == FUNC_SEND) begin
      r = '{KIND_FWD, c.tag, c.mtime, c.frag, c.handle, 1'b1};
      if (c.rel) begin
        for (int i = DEPTH - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
        if (hit >= 0) r.kind = KIND_DUP;
        else if (slot < 0) r.kind = KIND_FULL;
        else begin
          tbl_valid[slot] = 1'b1;
          tbl_entry[slot] = c;
        end
      end
      expected_results.push_back(r);
      return;
    end
    if (hit >= 0) tbl_valid[hit] = 1'b0;
    if (c.mtime > acked_max) acked_max = c.mtime;
    gap = (rtt_big >= rtt_min) ? 32'(rtt_big - rtt_min) : 32'd0;
    thr = (acked_max >= gap) ? acked_max - gap : 32'd0;
    for (int i = 0; i < DEPTH; i++) aged[i] = tbl_valid[i] && tbl_entry[i].mtime < thr;
    while (n < MAX_RESULTS) begin
      best = -1;
      for (int i = 0; i < DEPTH; i++)
        if (aged[i] && (best < 0 || key_below(tbl_entry[i], tbl_entry[best]))) best = i;
      if (best < 0) break;
      expected_results.push_back('{KIND_RETX, tbl_entry[best].tag, tbl_entry[best].mtime,
                                   tbl_entry[best].frag, tbl_entry[best].handle, 1'b0});
      aged[best] = 1'b0;
      tbl_valid[best] = 1'b0;
      n++;
    end
    if (n > 0) expected_results[$].last = 1'b1;
  endtask

  logic accepted;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    accepted = start && !busy;
    if (accepted) predict_table('{func_i, name_tag_i, media_time_i, fragment_i,
                                  reliable_i, packet_handle_i});
    // monitor
    if (result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual kind %0d tag %h", $time,
                 result_kind_o, out_tag_o);
        fail_count++;
      end else begin
        res_item_t e;
        e = expected_results.pop_front();
        if (e != {result_kind_o, out_tag_o, out_time_o, out_fragment_o, out_handle_o,
                  last_o}) begin
          $display("%0t result mismatch: expected %h actual %h", $time, e,
                   {result_kind_o, out_tag_o, out_time_o, out_fragment_o,
                    out_handle_o, last_o});
          fail_count++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // command driver: start stays up while busy; after acceptance next item or idle
  logic busy_q_at_edge;
  always @(posedge clk_i) busy_q_at_edge <= busy;

  logic took;
  always @(negedge clk_i) begin
    took = start && !busy_q_at_edge;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (driving && pending_cmds.size() > 0 &&
          (quiet_stretch || $urandom_range(99) >= 33)) begin
        cmd_item_t c;
        c = pending_cmds.pop_front();
        start <= 1'b1;
        {func_i, name_tag_i, media_time_i, fragment_i, reliable_i, packet_handle_i} <= c;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_MIN_RTT) rtt_min = val; else rtt_big = val;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // let everything queued drain, then wait out the block's own latency
  task automatic drain_all();
    driving = 1'b1;
    while (pending_cmds.size() > 0 || start) @(posedge clk_i);
    while (busy || expected_results.size() > 0) @(posedge clk_i);
    repeat (3 * DEPTH + 8) @(posedge clk_i);
    driving = 1'b0;
  endtask

  function automatic cmd_item_t mk(logic f, logic [31:0] t, logic [31:0] m, logic [7:0] fr,
                                   logic r, logic [15:0] h);
    return '{f, t, m, fr, r, h};
  endfunction

  // a random mix of sends, mostly reliable, and acks; names from small pools so hits happen
  task automatic random_phase(input int count, input logic [31:0] tbase, input int tspan);
    cmd_item_t c;
    for (int k = 0; k < count; k++) begin
      c.func = ($urandom_range(99) < 30) ? FUNC_ACK : FUNC_SEND;
      c.tag = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(3));
      c.mtime = ($urandom_range(19) == 0) ? $urandom() : tbase + $urandom_range(tspan);
      c.frag = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(2));
      c.rel = ($urandom_range(9) != 0);
      c.handle = 16'($urandom());
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    acked_max = '0;
    rtt_min = RESET_MIN_RTT;
    rtt_big = RESET_BIG_RTT;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: passthrough, duplicate, extremes, unknown ack, ack with nothing aged
    pending_cmds.push_back(mk(FUNC_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, 16'hFFFF));
    pending_cmds.push_back(mk(FUNC_SEND, 0, 0, 0, 1'b1, 0));
    pending_cmds.push_back(mk(FUNC_SEND, 0, 0, 0, 1'b1, 16'h1234));
    pending_cmds.push_back(mk(FUNC_SEND, 32'hFFFF_FFFF, 32'd500, 8'hFF, 1'b1, 16'hFFFF));
    pending_cmds.push_back(mk(FUNC_SEND, 5, 150, 1, 1'b1, 16'h00AA));
    pending_cmds.push_back(mk(FUNC_SEND, 5, 150, 0, 1'b1, 16'h00BB));
    pending_cmds.push_back(mk(FUNC_ACK, 7, 50, 3, 1'b1, 16'hFFFF));
    pending_cmds.push_back(mk(FUNC_ACK, 0, 0, 0, 1'b0, 0));
    pending_cmds.push_back(mk(FUNC_ACK, 9, 300, 9, 1'b0, 0));
    pending_cmds.push_back(mk(FUNC_ACK, 9, 32'hFFFF_FFFF, 9, 1'b0, 0));
    drain_all();

    // fill the table to overflow, then flush with the reset round trip times
    for (int i = 0; i <= DEPTH; i++)
      pending_cmds.push_back(mk(FUNC_SEND, 32'(i), 32'hFFFF_FF00, 8'(i), 1'b1, 16'(i)));
    pending_cmds.push_back(mk(FUNC_ACK, 1, 32'hFFFF_FF00, 1, 1'b0, 0));
    drain_all();

    // inverted round trip times and extremes; acked maximum is saturated now, so
    // later phases must stay below it only via config that keeps thresholds low
    write_reg(REG_MIN_RTT, 16'hFFFF);
    write_reg(REG_BIG_RTT, 16'h0000);
    quiet_stretch = 1'b1;
    random_phase(60, 32'hFFFF_FE00, 200);
    drain_all();
    quiet_stretch = 1'b0;

    write_reg(REG_MIN_RTT, 16'h0000);
    write_reg(REG_BIG_RTT, 16'hFFFF);
    random_phase(105, 32'hFFFE_0000, 32'h1FFFF);
    drain_all();

    write_reg(REG_MIN_RTT, 16'd10);
    write_reg(REG_BIG_RTT, 16'd40);
    random_phase(105, 32'hFFFF_FF00, 250);
    drain_all();

    write_reg(REG_MIN_RTT, RESET_MIN_RTT);
    write_reg(REG_BIG_RTT, RESET_BIG_RTT);
    random_phase(105, 32'hFFFF_FC00, 1000);
    drain_all();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
